@@ design/hrgl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes, constants and build-time term functions for the het-ratio grid block.
package hrgl_pkg;

    typedef logic signed [31:0] llr_t;

    localparam int QUALITY_W   = 6;
    localparam int BASE_W      = 3;
    localparam int REF_BASE_W  = 2;
    localparam int STEPS_W     = 4;
    localparam int SLOT_OUT_W  = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_BASE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HET_STEPS      = 1'b1;

    localparam logic [REF_BASE_W-1:0] REF_BASE_RESET  = 2'd0;
    localparam logic [STEPS_W-1:0]    HET_STEPS_RESET = 4'd4;

    localparam llr_t LLR_MIN = 32'sh8000_0000;
    localparam llr_t LLR_MAX = 32'sh7FFF_FFFF;

    localparam logic [63:0] ONE_Q32          = 64'h1_0000_0000;
    localparam logic [63:0] HALF_Q32         = 64'h0_8000_0000;
    localparam logic [63:0] TENTH_DECADE_Q32 = 64'd3411613790;
    localparam logic [63:0] LN2_Q30          = 64'd744261118;
    localparam int          LOG2_FRAC_BITS   = 28;
    localparam logic [63:0] PERMILLE_ONE     = 64'd1000;
    localparam logic [63:0] MIX_DENOM        = 64'd3000;

    // Natural log of a Q32 probability, as a non-positive fixed-point value.
    function automatic llr_t ln_q32(input logic [63:0] x, input int frac_bits);
        logic [63:0] y;
        logic [63:0] frac;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] mag_out;
        int          n;
        int          sh;
        y    = x;
        frac = '0;
        n    = 0;
        sh   = 58 - frac_bits;
        if (x == 64'd0)
            return LLR_MIN;
        if (x >= ONE_Q32)
            return '0;
        for (int i = 0; i < 32; i++)
        begin
            if (y < HALF_Q32)
            begin
                y = y << 1;
                n = n + 1;
            end
        end
        for (int i = 1; i <= LOG2_FRAC_BITS; i++)
        begin
            y = (y * y) >> 31;
            if (y >= ONE_Q32)
            begin
                y    = y >> 1;
                frac = frac | (64'd1 << (LOG2_FRAC_BITS - i));
            end
        end
        mag     = (64'(n + 1) << LOG2_FRAC_BITS) - frac;
        prod    = mag * LN2_Q30;
        mag_out = (prod + (64'd1 << (sh - 1))) >> sh;
        if (mag_out > 64'h7FFF_FFFF)
            return LLR_MIN;
        return 32'(64'd0 - mag_out);
    endfunction

    // Log term for quality q and ratio step k; sel_b picks the mirrored term.
    function automatic llr_t term_value(input int q, input int k, input logic sel_b,
                                        input int ratio_permille, input int frac_bits);
        logic [63:0] e;
        logic [63:0] ce;
        logic [63:0] rp;
        logic [63:0] xa;
        logic [63:0] xb;
        e = ONE_Q32;
        for (int i = 1; i <= q; i++)
            e = (e * TENTH_DECADE_Q32 + HALF_Q32) >> 32;
        ce = ONE_Q32 - e;
        rp = 64'((k + 1) * ratio_permille);
        if (rp > PERMILLE_ONE)
            rp = PERMILLE_ONE;
        xa = (64'd3 * ce * rp + e * (PERMILLE_ONE - rp)) / MIX_DENOM;
        xb = (64'd3 * ce * (PERMILLE_ONE - rp) + e * rp) / MIX_DENOM;
        return ln_q32(sel_b ? xb : xa, frac_bits);
    endfunction

    // Signed add that clamps at both ends of the 32-bit range.
    function automatic llr_t sat_add32(input llr_t a, input llr_t b);
        logic signed [32:0] sum;
        sum = 33'(a) + 33'(b);
        if (sum[32] != sum[31])
            return sum[32] ? LLR_MIN : LLR_MAX;
        return sum[31:0];
    endfunction

endpackage

@@ design/hrgl_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
interface hrgl_cfg_if;
    import hrgl_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/hrgl_in_if.sv @@
`timescale 1ns / 1ps
// Input channel carrying base calls and finish commands.
interface hrgl_in_if;
    import hrgl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [QUALITY_W-1:0] call_quality;
    logic [BASE_W-1:0]    observed_base;

    modport source (output valid, output command, output call_quality, output observed_base,
                    input ready);
    modport sink (input valid, input command, input call_quality, input observed_base,
                  output ready);
endinterface

@@ design/hrgl_out_if.sv @@
`timescale 1ns / 1ps
// Output channel carrying one accumulated slot per transaction.
interface hrgl_out_if;
    import hrgl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SLOT_OUT_W-1:0] slot_index;
    llr_t                  log_likelihood;
    logic                  last;

    modport source (output valid, output slot_index, output log_likelihood, output last,
                    input ready);
    modport sink (input valid, input slot_index, input log_likelihood, input last,
                  output ready);
endinterface

@@ design/hrgl_term_rom.sv @@
`timescale 1ns / 1ps
// Constant log-term table indexed by quality and ratio step, with a registered read.
module hrgl_term_rom #(
    parameter int MAX_HET_STEPS       = 8,
    parameter int RATIO_STEP_PERMILLE = 100,
    parameter int MAX_QUALITY         = 63,
    parameter int FRACTION_BITS       = 10,
    parameter int Q_W                 = 6,
    parameter int K_W                 = 3
) (
    input  logic             clk,
    input  logic [Q_W-1:0]   quality,
    input  logic [K_W-1:0]   step,
    output hrgl_pkg::llr_t   term_a,
    output hrgl_pkg::llr_t   term_b
);
    import hrgl_pkg::*;

    logic [63:0] rom [MAX_QUALITY+1][MAX_HET_STEPS];
    llr_t        term_a_reg;
    llr_t        term_b_reg;

    // Every entry is folded to a constant when the design is elaborated.
    for (genvar gq = 0; gq <= MAX_QUALITY; gq++)
    begin : g_q
        for (genvar gk = 0; gk < MAX_HET_STEPS; gk++)
        begin : g_k
            assign rom[gq][gk] = {term_value(gq, gk, 1'b1, RATIO_STEP_PERMILLE, FRACTION_BITS),
                                  term_value(gq, gk, 1'b0, RATIO_STEP_PERMILLE, FRACTION_BITS)};
        end
    end

    always_ff @(posedge clk)
    begin
        term_a_reg <= rom[quality][step][31:0];
        term_b_reg <= rom[quality][step][63:32];
    end

    assign term_a = term_a_reg;
    assign term_b = term_b_reg;
endmodule

@@ design/het_ratio_grid_likelihood.sv @@
`timescale 1ns / 1ps
// Het-ratio grid log-likelihood accumulator: top level.
//
// Configuration channel cfg writes reference_base (index 0) and het_steps (index 1);
// it is always ready and should only be used while the block is idle.
// Channel base_calls takes one command per transaction. A base call walks the
// S effective ratio steps, one step per cycle, updating the low and the high slot
// of that step through one shared pair of saturating adders fed by a registered
// term table. A base call holds the input until its last step is written back
// and produces nothing. A finish moves to the emit state and streams slots
// 0 .. 2*S-1 on slot_results, one per cycle while the receiver takes them;
// the whole grid is cleared to zero as the final slot is loaded into the output
// register. The slot sums sit in two banks (even and odd slots), one read and one
// write each per cycle, which sets the one-step-per-cycle pace.
// A result waiting in the output register does not block the next base call;
// while the receiver stalls, a finish holds its place in the slot sequence.
// Reset clears the grid, sets reference_base to 0 and het_steps to 4.
module het_ratio_grid_likelihood #(
    parameter int MAX_HET_STEPS       = 8,
    parameter int RATIO_STEP_PERMILLE = 100,
    parameter int MAX_QUALITY         = 63,
    parameter int FRACTION_BITS       = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    hrgl_cfg_if.sink   cfg,
    hrgl_in_if.sink    base_calls,
    hrgl_out_if.source slot_results
);
    import hrgl_pkg::*;

    localparam int K_W    = (MAX_HET_STEPS > 1) ? $clog2(MAX_HET_STEPS) : 1;
    localparam int SLOT_W = K_W + 1;
    localparam int Q_W    = $clog2(MAX_QUALITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [REF_BASE_W-1:0] ref_base_reg;
    logic [STEPS_W-1:0]    het_steps_reg;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [K_W-1:0]    k_cnt_reg;
    logic [K_W-1:0]    k_cnt_next;
    logic [SLOT_W-1:0] slot_cnt_reg;
    logic [SLOT_W-1:0] slot_cnt_next;
    logic [Q_W-1:0]    q_reg;
    logic [Q_W-1:0]    q_sat;
    logic              match_reg;

    logic [STEPS_W:0]  steps_eff;
    logic [K_W-1:0]    steps_m1;
    logic [SLOT_W-1:0] slot_last;
    logic [SLOT_W-1:0] lo_slot;
    logic [SLOT_W-1:0] hi_slot;
    logic [SLOT_W-1:0] even_slot;
    logic [SLOT_W-1:0] odd_slot;
    logic [K_W-1:0]    rd_even_addr;
    logic [K_W-1:0]    rd_odd_addr;

    llr_t             bank_even_mem [MAX_HET_STEPS];
    llr_t             bank_odd_mem [MAX_HET_STEPS];
    logic [MAX_HET_STEPS-1:0] vld_even_reg;
    logic [MAX_HET_STEPS-1:0] vld_odd_reg;
    llr_t             rd_even_reg;
    llr_t             rd_odd_reg;
    logic             rd_even_vld_reg;
    logic             rd_odd_vld_reg;

    logic             p1_vld_reg;
    logic             p1_lo_even_reg;
    logic [K_W-1:0]   p1_even_addr_reg;
    logic [K_W-1:0]   p1_odd_addr_reg;

    llr_t             term_a;
    llr_t             term_b;
    llr_t             lo_term;
    llr_t             hi_term;
    llr_t             even_old;
    llr_t             odd_old;
    llr_t             sum_even;
    llr_t             sum_odd;
    llr_t             emit_val;

    logic             in_fire;
    logic             load_fire;
    logic             emit_last;

    logic                  out_vld_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    llr_t                  out_ll_reg;
    logic                  out_last_reg;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_base_reg  <= REF_BASE_RESET;
            het_steps_reg <= HET_STEPS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_REFERENCE_BASE: ref_base_reg  <= cfg.data[REF_BASE_W-1:0];
                REG_HET_STEPS:      het_steps_reg <= cfg.data[STEPS_W-1:0];
                default:            ref_base_reg  <= ref_base_reg;
            endcase
        end
    end

    // Effective step count, clamped to 1 .. MAX_HET_STEPS.
    always_comb
    begin
        if (het_steps_reg == '0)
            steps_eff = (STEPS_W+1)'(1);
        else if ({1'b0, het_steps_reg} > (STEPS_W+1)'(MAX_HET_STEPS))
            steps_eff = (STEPS_W+1)'(MAX_HET_STEPS);
        else
            steps_eff = {1'b0, het_steps_reg};
    end

    assign steps_m1  = K_W'(steps_eff - (STEPS_W+1)'(1));
    assign slot_last = {steps_m1, 1'b1};

    // Input capture.
    assign base_calls.ready = (state_reg == ST_IDLE) && !p1_vld_reg;
    assign in_fire          = base_calls.valid && base_calls.ready;

    always_comb
    begin
        if (32'(base_calls.call_quality) > MAX_QUALITY)
            q_sat = Q_W'(MAX_QUALITY);
        else
            q_sat = Q_W'(base_calls.call_quality);
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            q_reg     <= q_sat;
            match_reg <= (base_calls.observed_base == BASE_W'(ref_base_reg));
        end
    end

    // Sequencer.
    assign emit_last = (slot_cnt_reg == slot_last);
    assign load_fire = (state_reg == ST_EMIT) && (!out_vld_reg || slot_results.ready);

    always_comb
    begin
        state_next    = state_reg;
        k_cnt_next    = '0;
        slot_cnt_next = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = (base_calls.command == CMD_FINISH) ? ST_EMIT : ST_ADD;
            end
            ST_ADD:
            begin
                if (k_cnt_reg == steps_m1)
                    state_next = ST_IDLE;
                else
                    k_cnt_next = k_cnt_reg + K_W'(1);
            end
            ST_EMIT:
            begin
                slot_cnt_next = slot_cnt_reg;
                if (load_fire)
                begin
                    if (emit_last)
                    begin
                        state_next    = ST_IDLE;
                        slot_cnt_next = '0;
                    end
                    else
                        slot_cnt_next = slot_cnt_reg + SLOT_W'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            k_cnt_reg    <= '0;
            slot_cnt_reg <= '0;
            p1_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_cnt_reg    <= k_cnt_next;
            slot_cnt_reg <= slot_cnt_next;
            p1_vld_reg   <= (state_reg == ST_ADD);
        end
    end

    // The two slots of a ratio step always have opposite parity, so each bank
    // sees exactly one of them.
    assign lo_slot   = SLOT_W'(k_cnt_reg);
    assign hi_slot   = slot_last - lo_slot;
    assign even_slot = k_cnt_reg[0] ? hi_slot : lo_slot;
    assign odd_slot  = k_cnt_reg[0] ? lo_slot : hi_slot;

    // While streaming, the read tracks the next slot so that the read registers
    // always hold the slot named by the slot counter.
    assign rd_even_addr = (state_reg == ST_ADD) ? even_slot[SLOT_W-1:1]
                                                : slot_cnt_next[SLOT_W-1:1];
    assign rd_odd_addr  = (state_reg == ST_ADD) ? odd_slot[SLOT_W-1:1]
                                                : slot_cnt_next[SLOT_W-1:1];

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ADD)
        begin
            p1_lo_even_reg   <= !k_cnt_reg[0];
            p1_even_addr_reg <= even_slot[SLOT_W-1:1];
            p1_odd_addr_reg  <= odd_slot[SLOT_W-1:1];
        end
    end

    hrgl_term_rom #(
        .MAX_HET_STEPS       (MAX_HET_STEPS),
        .RATIO_STEP_PERMILLE (RATIO_STEP_PERMILLE),
        .MAX_QUALITY         (MAX_QUALITY),
        .FRACTION_BITS       (FRACTION_BITS),
        .Q_W                 (Q_W),
        .K_W                 (K_W)
    ) u_term_rom (
        .clk     (clk),
        .quality (q_reg),
        .step    (k_cnt_reg),
        .term_a  (term_a),
        .term_b  (term_b)
    );

    // Shared pair of saturating adders.
    assign even_old = rd_even_vld_reg ? rd_even_reg : '0;
    assign odd_old  = rd_odd_vld_reg ? rd_odd_reg : '0;
    assign hi_term  = match_reg ? term_a : term_b;
    assign lo_term  = match_reg ? term_b : term_a;
    assign sum_even = sat_add32(even_old, p1_lo_even_reg ? lo_term : hi_term);
    assign sum_odd  = sat_add32(odd_old, p1_lo_even_reg ? hi_term : lo_term);

    always_ff @(posedge clk)
    begin
        if (p1_vld_reg)
        begin
            bank_even_mem[p1_even_addr_reg] <= sum_even;
            bank_odd_mem[p1_odd_addr_reg]   <= sum_odd;
        end
        rd_even_reg <= bank_even_mem[rd_even_addr];
        rd_odd_reg  <= bank_odd_mem[rd_odd_addr];
    end

    // A slot whose valid bit is clear reads as zero; finishing clears them all.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_even_reg    <= '0;
            vld_odd_reg     <= '0;
            rd_even_vld_reg <= 1'b0;
            rd_odd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (load_fire && emit_last)
            begin
                vld_even_reg <= '0;
                vld_odd_reg  <= '0;
            end
            else if (p1_vld_reg)
            begin
                vld_even_reg[p1_even_addr_reg] <= 1'b1;
                vld_odd_reg[p1_odd_addr_reg]   <= 1'b1;
            end
            rd_even_vld_reg <= vld_even_reg[rd_even_addr];
            rd_odd_vld_reg  <= vld_odd_reg[rd_odd_addr];
        end
    end

    // Output register.
    assign emit_val = slot_cnt_reg[0] ? odd_old : even_old;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (load_fire)
            out_vld_reg <= 1'b1;
        else if (slot_results.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            out_slot_reg <= SLOT_OUT_W'(slot_cnt_reg);
            out_ll_reg   <= emit_val;
            out_last_reg <= emit_last;
        end
    end

    assign slot_results.valid          = out_vld_reg;
    assign slot_results.slot_index     = out_slot_reg;
    assign slot_results.log_likelihood = out_ll_reg;
    assign slot_results.last           = out_last_reg;

    a_no_writeback_while_streaming: assert property (@(posedge clk) disable iff (!rst_n)
        !(p1_vld_reg && load_fire))
        else $error("slot writeback collided with result streaming");

    a_grid_cleared_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (load_fire && emit_last) |=> (vld_even_reg == '0 && vld_odd_reg == '0))
        else $error("grid not cleared after final slot");

    a_result_not_positive: assert property (@(posedge clk) disable iff (!rst_n)
        slot_results.valid |->
            (slot_results.log_likelihood[31] || slot_results.log_likelihood == '0))
        else $error("positive log likelihood emitted");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> (k_cnt_reg <= steps_m1))
        else $error("ratio step counter past effective step count");

endmodule

@@ test/tb_het_ratio_grid_likelihood.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the het-ratio grid log-likelihood accumulator.
module tb_het_ratio_grid_likelihood;
    import hrgl_pkg::*;

    localparam int NUM_STEPS_MAX = 8;
    localparam int STEP_PERMILLE = 100;
    localparam int TOP_QUALITY   = 63;
    localparam int LLR_FRAC_BITS = 10;
    localparam int GRID_SLOTS    = 2 * NUM_STEPS_MAX;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        logic                 command;
        logic [QUALITY_W-1:0] quality;
        logic [BASE_W-1:0]    base;
    } call_t;

    typedef struct {
        logic [SLOT_OUT_W-1:0] slot;
        llr_t                  llr;
        logic                  last;
    } slot_result_t;

    logic clk = 1'b0;
    logic rst_n;

    hrgl_cfg_if cfg_ch();
    hrgl_in_if  call_ch();
    hrgl_out_if slot_ch();

    het_ratio_grid_likelihood #(
        .MAX_HET_STEPS      (NUM_STEPS_MAX),
        .RATIO_STEP_PERMILLE(STEP_PERMILLE),
        .MAX_QUALITY        (TOP_QUALITY),
        .FRACTION_BITS      (LLR_FRAC_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .base_calls  (call_ch),
        .slot_results(slot_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Term tables: ln P(call | ratio r) and its mirror ln P(call | ratio 1-r).
    llr_t lik_ratio [0:TOP_QUALITY][0:NUM_STEPS_MAX-1];
    llr_t lik_mirror[0:TOP_QUALITY][0:NUM_STEPS_MAX-1];
    llr_t grid_sum  [0:GRID_SLOTS-1];

    logic [REF_BASE_W-1:0] ref_base_q;
    logic [STEPS_W-1:0]    het_steps_q;

    slot_result_t expected_slots[$];
    call_t        pending_calls[$];

    int calls_queued   = 0;
    int calls_accepted = 0;
    int mismatches     = 0;
    bit call_taken     = 1'b0;
    int send_hold      = 0;
    int recv_hold      = 0;
    bit send_burst     = 1'b0;
    bit recv_burst     = 1'b0;

    function automatic llr_t ln_prob_q32(input bit [63:0] p);
        bit [63:0] m;
        bit [63:0] log2_bits;
        bit [63:0] mag;
        int        shifts;
        if (p == 64'd0)
            return LLR_MIN;
        if (p >= ONE_Q32)
            return '0;
        m      = p;
        shifts = 0;
        while (m < HALF_Q32)
        begin
            m      = m << 1;
            shifts = shifts + 1;
        end
        // Each squaring yields one more fractional bit of log2, most significant first.
        log2_bits = '0;
        for (int i = 0; i < LOG2_FRAC_BITS; i++)
        begin
            m         = (m * m) >> 31;
            log2_bits = log2_bits << 1;
            if (m >= ONE_Q32)
            begin
                m         = m >> 1;
                log2_bits = log2_bits | 64'd1;
            end
        end
        mag = (64'(shifts + 1) << LOG2_FRAC_BITS) - log2_bits;
        mag = (mag * LN2_Q30 + (64'd1 << (57 - LLR_FRAC_BITS))) >> (58 - LLR_FRAC_BITS);
        if (mag > 64'h7FFF_FFFF)
            return LLR_MIN;
        return -llr_t'(mag[31:0]);
    endfunction

    function automatic void build_term_tables();
        bit [63:0] err_p;
        bit [63:0] hit_p;
        bit [63:0] rp;
        bit [63:0] p_ratio;
        bit [63:0] p_mirror;
        err_p = ONE_Q32;
        for (int q = 0; q <= TOP_QUALITY; q++)
        begin
            if (q != 0)
                err_p = (err_p * TENTH_DECADE_Q32 + HALF_Q32) >> 32;
            hit_p = ONE_Q32 - err_p;
            for (int k = 0; k < NUM_STEPS_MAX; k++)
            begin
                rp = 64'((k + 1) * STEP_PERMILLE);
                if (rp > PERMILLE_ONE)
                    rp = PERMILLE_ONE;
                p_ratio  = (3 * hit_p * rp + err_p * (PERMILLE_ONE - rp)) / MIX_DENOM;
                p_mirror = (3 * hit_p * (PERMILLE_ONE - rp) + err_p * rp) / MIX_DENOM;
                lik_ratio[q][k]  = ln_prob_q32(p_ratio);
                lik_mirror[q][k] = ln_prob_q32(p_mirror);
            end
        end
    endfunction

    function automatic int active_steps();
        if (het_steps_q == '0)
            return 1;
        if (het_steps_q > NUM_STEPS_MAX)
            return NUM_STEPS_MAX;
        return int'(het_steps_q);
    endfunction

    function automatic llr_t clamp_add(input llr_t acc, input llr_t term);
        longint total;
        total = longint'(acc) + longint'(term);
        if (total < longint'(LLR_MIN))
            return LLR_MIN;
        if (total > longint'(LLR_MAX))
            return LLR_MAX;
        return llr_t'(total);
    endfunction

    function automatic void accumulate_call(input logic [QUALITY_W-1:0] q,
                                            input logic [BASE_W-1:0] base);
        int steps;
        int top;
        bit hit;
        steps = active_steps();
        top   = 2 * steps - 1;
        hit   = (base == {1'b0, ref_base_q});
        for (int k = 0; k < steps; k++)
        begin
            grid_sum[top - k] = clamp_add(grid_sum[top - k],
                                          hit ? lik_ratio[q][k] : lik_mirror[q][k]);
            grid_sum[k]       = clamp_add(grid_sum[k],
                                          hit ? lik_mirror[q][k] : lik_ratio[q][k]);
        end
    endfunction

    function automatic void emit_position();
        slot_result_t res;
        int           total;
        total = 2 * active_steps();
        for (int k = 0; k < total; k++)
        begin
            res.slot = SLOT_OUT_W'(k);
            res.llr  = grid_sum[k];
            res.last = (k == total - 1);
            expected_slots.push_back(res);
        end
        for (int k = 0; k < GRID_SLOTS; k++)
            grid_sum[k] = '0;
    endfunction

    function automatic int idle_length(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void queue_call(input logic command, input logic [QUALITY_W-1:0] q,
                                       input logic [BASE_W-1:0] base);
        call_t c;
        c.command = command;
        c.quality = q;
        c.base    = base;
        pending_calls.push_back(c);
        calls_queued++;
    endfunction

    function automatic logic [QUALITY_W-1:0] pick_quality();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return QUALITY_W'(TOP_QUALITY);
        return QUALITY_W'($urandom_range(0, TOP_QUALITY));
    endfunction

    // Mostly matches and plain mismatches; unknown and out-of-range codes now and then.
    function automatic logic [BASE_W-1:0] pick_base();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return {1'b0, ref_base_q};
        if (r < 85)
            return BASE_W'($urandom_range(0, 3));
        if (r < 93)
            return BASE_W'(4);
        return BASE_W'($urandom_range(5, 7));
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == REG_REFERENCE_BASE)
            ref_base_q = value[REF_BASE_W-1:0];
        else
            het_steps_q = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // A base call leaves no result behind, so the block may still be busy; give it time.
    task automatic settle();
        while (calls_accepted != calls_queued || expected_slots.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && call_ch.valid && call_ch.ready)
        begin
            if (call_ch.command == CMD_FINISH)
                emit_position();
            else
                accumulate_call(call_ch.call_quality, call_ch.observed_base);
            call_taken = 1'b1;
            calls_accepted++;
        end
    end

    always @(negedge clk)
    begin : drive_calls
        call_t next_call;
        if (!rst_n)
            call_ch.valid <= 1'b0;
        else if (!call_ch.valid || call_taken)
        begin
            call_taken = 1'b0;
            if (send_hold > 0)
            begin
                call_ch.valid <= 1'b0;
                send_hold--;
            end
            else if (pending_calls.size() != 0)
            begin
                next_call = pending_calls.pop_front();
                call_ch.valid         <= 1'b1;
                call_ch.command       <= next_call.command;
                call_ch.call_quality  <= next_call.quality;
                call_ch.observed_base <= next_call.base;
                send_hold = idle_length(send_burst);
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
            end
            else
                call_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            slot_ch.ready <= 1'b0;
        else if (recv_hold > 0)
        begin
            slot_ch.ready <= 1'b0;
            recv_hold--;
        end
        else
        begin
            slot_ch.ready <= 1'b1;
            recv_hold = idle_length(recv_burst);
            if ($urandom_range(0, 59) == 0)
                recv_burst = !recv_burst;
        end
    end

    always @(posedge clk)
    begin : check_slots
        slot_result_t want;
        if (rst_n && slot_ch.valid && slot_ch.ready)
        begin
            if (expected_slots.size() == 0)
            begin
                $error("slot_index: expected no transaction, actual %0d", slot_ch.slot_index);
                mismatches++;
            end
            else
            begin
                want = expected_slots.pop_front();
                if (slot_ch.slot_index !== want.slot)
                begin
                    $error("slot_index: expected %0d, actual %0d", want.slot, slot_ch.slot_index);
                    mismatches++;
                end
                if (slot_ch.log_likelihood !== want.llr)
                begin
                    $error("log_likelihood: expected %0d, actual %0d",
                           want.llr, slot_ch.log_likelihood);
                    mismatches++;
                end
                if (slot_ch.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, slot_ch.last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int r;
        int n;
        int phase_items;
        int step_plan[6];
        step_plan = '{8, 1, 15, 0, 2, 5};

        rst_n                 = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        call_ch.valid         = 1'b0;
        call_ch.command       = CMD_ADD;
        call_ch.call_quality  = '0;
        call_ch.observed_base = '0;
        slot_ch.ready         = 1'b0;

        build_term_tables();
        ref_base_q  = REF_BASE_RESET;
        het_steps_q = HET_STEPS_RESET;
        for (int k = 0; k < GRID_SLOTS; k++)
            grid_sum[k] = '0;

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty grid, quality extremes, unknown and out-of-range bases,
        // then two finishes back to back.
        queue_call(CMD_FINISH, QUALITY_W'(TOP_QUALITY), BASE_W'(7));
        queue_call(CMD_ADD, QUALITY_W'(0), BASE_W'(0));
        queue_call(CMD_ADD, QUALITY_W'(TOP_QUALITY), BASE_W'(0));
        queue_call(CMD_ADD, QUALITY_W'(TOP_QUALITY), BASE_W'(4));
        queue_call(CMD_ADD, QUALITY_W'(TOP_QUALITY), BASE_W'(7));
        queue_call(CMD_ADD, QUALITY_W'(1), BASE_W'(3));
        queue_call(CMD_ADD, QUALITY_W'(10), BASE_W'(1));
        queue_call(CMD_FINISH, QUALITY_W'(0), BASE_W'(0));
        queue_call(CMD_FINISH, QUALITY_W'(0), BASE_W'(0));
        settle();

        // Full grid, position left open across a step-count change.
        write_reg(REG_REFERENCE_BASE, CFG_DATA_W'(3));
        write_reg(REG_HET_STEPS, CFG_DATA_W'(8));
        queue_call(CMD_ADD, QUALITY_W'(TOP_QUALITY), BASE_W'(3));
        queue_call(CMD_ADD, QUALITY_W'(30), BASE_W'(2));
        queue_call(CMD_ADD, QUALITY_W'(0), BASE_W'(5));
        queue_call(CMD_ADD, QUALITY_W'(45), BASE_W'(3));
        settle();
        write_reg(REG_HET_STEPS, CFG_DATA_W'(1));
        queue_call(CMD_ADD, QUALITY_W'(20), BASE_W'(3));
        queue_call(CMD_ADD, QUALITY_W'(TOP_QUALITY), BASE_W'(6));
        queue_call(CMD_FINISH, QUALITY_W'(37), BASE_W'(2));
        settle();

        // A step count of zero acts as one, anything above the maximum as the maximum.
        write_reg(REG_HET_STEPS, CFG_DATA_W'(0));
        queue_call(CMD_ADD, QUALITY_W'(TOP_QUALITY), BASE_W'(3));
        queue_call(CMD_FINISH, QUALITY_W'(0), BASE_W'(0));
        settle();
        write_reg(REG_HET_STEPS, CFG_DATA_W'(15));
        write_reg(REG_REFERENCE_BASE, CFG_DATA_W'(4'b1110));
        queue_call(CMD_ADD, QUALITY_W'(TOP_QUALITY), BASE_W'(2));
        queue_call(CMD_ADD, QUALITY_W'(5), BASE_W'(0));
        queue_call(CMD_FINISH, QUALITY_W'(TOP_QUALITY), BASE_W'(7));
        settle();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_HET_STEPS, CFG_DATA_W'(step_plan[p]));
            write_reg(REG_REFERENCE_BASE, {2'($urandom_range(0, 3)), 2'(p % 4)});
            phase_items = 0;
            while (phase_items < 55)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    n = 0;
                else if (r < 85)
                    n = $urandom_range(1, 8);
                else
                    n = $urandom_range(9, 24);
                repeat (n)
                    queue_call(CMD_ADD, pick_quality(), pick_base());
                queue_call(CMD_FINISH, QUALITY_W'($urandom), BASE_W'($urandom));
                phase_items += n + 1;
            end
            // Odd phases leave a position open so that it spans the next step-count change.
            if (p % 2 == 1)
                repeat ($urandom_range(1, 6))
                    queue_call(CMD_ADD, pick_quality(), pick_base());
            settle();
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
